@@ rtl/core/olte_pkg.sv @@
`timescale 1ns / 1ps
package olte_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOCATE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } item_t;

    typedef struct packed {
        logic               success;
        logic signed [31:0] removed_value;
        logic [6:0]         found_position;
        logic [6:0]         list_count;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } ctrl_t;

    typedef struct packed {
        logic is_locate;
        logic hit;
        logic last;
    } stat_t;

endpackage

@@ rtl/core/olte_ctrl.sv @@
`timescale 1ns / 1ps
module olte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  olte_pkg::stat_t stat,
    output logic           busy,
    output logic           done,
    output olte_pkg::ctrl_t ctrl
);
    import olte_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        busy      = state_reg inside {S_EXEC, S_SCAN};
        done      = (state_reg == S_RESP);
        ctrl.load = start && !busy;
        ctrl.exec = (state_reg == S_EXEC);
        ctrl.scan = (state_reg == S_SCAN);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_RESP:
            begin
                state_next = start ? S_EXEC : S_IDLE;
            end
            S_EXEC:
            begin
                state_next = stat.is_locate ? S_SCAN : S_RESP;
            end
            S_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = S_RESP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/olte_dpath.sv @@
`timescale 1ns / 1ps
module olte_dpath #(
    parameter int DEPTH = olte_pkg::DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  olte_pkg::item_t   item,
    input  olte_pkg::ctrl_t   ctrl,
    output olte_pkg::stat_t   stat,
    output olte_pkg::result_t result
);
    import olte_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int MW  = ((CW > 7) ? CW : 7) + 1;
    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCH = (DEPTH + 7) / 8;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int FW  = KW + 4;

    logic [1:0]           op_reg;
    logic [6:0]           pos_reg;
    logic [31:0]          val_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [31:0]          entries_reg [DEPTH];
    logic [31:0]          entries_next [DEPTH];
    logic [NCH*8-1:0]     match_reg;
    logic [NCH*8-1:0]     match_next;
    logic [KW-1:0]        chunk_reg;
    result_t              res_reg;
    result_t              res_exec;

    logic [MW-1:0]        pos_x;
    logic [MW-1:0]        cnt_x;
    logic [MW-1:0]        pos_m1;
    logic [IW-1:0]        del_idx;
    logic                 ins_ok;
    logic                 del_ok;
    logic [CW+6:0]        cnt_ext;
    logic [7:0]           chunk_bits;
    logic [2:0]           enc;
    logic [FW-1:0]        found_full;
    logic [FW+6:0]        found_ext;

    assign pos_x   = {{(MW-7){1'b0}}, pos_reg};
    assign cnt_x   = {{(MW-CW){1'b0}}, count_reg};
    assign pos_m1  = pos_x - MW'(1);
    assign del_idx = pos_m1[IW-1:0];
    assign ins_ok  = (op_reg == OP_INSERT) && (pos_x != '0) && (pos_x <= cnt_x + MW'(1))
                     && (cnt_x < MW'(DEPTH));
    assign del_ok  = (op_reg == OP_DELETE) && (pos_x != '0) && (pos_x <= cnt_x);

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign cnt_ext = {7'b0, count_next};

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (ins_ok)
            begin
                if (MW'(i) == pos_m1)
                begin
                    entries_next[i] = val_reg;
                end
                else if ((MW'(i) >= pos_x) && (i > 0))
                begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (del_ok)
            begin
                if ((MW'(i) >= pos_m1) && (i < DEPTH - 1))
                begin
                    entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb
    begin
        match_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (entries_reg[i] == val_reg) && (MW'(i) < cnt_x);
        end
    end

    always_comb
    begin
        res_exec.success        = ins_ok || del_ok;
        res_exec.removed_value  = del_ok ? entries_reg[del_idx] : 32'sd0;
        res_exec.found_position = 7'd0;
        res_exec.list_count     = cnt_ext[6:0];
    end

    assign chunk_bits = match_reg[chunk_reg*8 +: 8];

    always_comb
    begin
        enc = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (chunk_bits[i])
            begin
                enc = 3'(i);
            end
        end
    end

    assign found_full = FW'({chunk_reg, 3'b000}) + FW'(enc) + FW'(1);
    assign found_ext  = {7'b0, found_full};

    assign stat.is_locate = (op_reg == OP_LOCATE);
    assign stat.hit       = |chunk_bits;
    assign stat.last      = (chunk_reg == KW'(NCH - 1));

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg  <= item.op;
            pos_reg <= item.position;
            val_reg <= item.item_value;
        end
        if (ctrl.exec)
        begin
            entries_reg <= entries_next;
            match_reg   <= match_next;
            res_reg     <= res_exec;
        end
        if (ctrl.scan && (stat.hit || stat.last))
        begin
            res_reg.success        <= stat.hit;
            res_reg.removed_value  <= 32'sd0;
            res_reg.found_position <= stat.hit ? found_ext[6:0] : 7'd0;
            res_reg.list_count     <= cnt_ext[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                count_reg <= count_next;
                chunk_reg <= '0;
            end
            else if (ctrl.scan)
            begin
                chunk_reg <= chunk_reg + KW'(1);
            end
        end
    end

    assign result = res_reg;

endmodule

@@ rtl/core/ordered_list_table_engine_top.sv @@
`timescale 1ns / 1ps
// Channel   Ports                  Handshake
// command   start, busy, item      taken at edge with start=1, busy=0
// result    done, result           valid for the single cycle done=1
//
// Insert, delete, unknown op: EXEC state, then done. Locate: EXEC, then SCAN
// until a hit or the last of ceil(DEPTH/8) chunks; the match vector is scanned
// 8 entries per cycle after one parallel compare across all cells.
// Reset clears the count and controller; list contents are not cleared.
// A new command may be issued in the cycle done is high; no output stall.
module ordered_list_table_engine_top #(
    parameter int DEPTH = olte_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  olte_pkg::item_t   item,
    output logic              done,
    output olte_pkg::result_t result
);
    import olte_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    olte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    olte_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctrl   (ctrl),
        .stat   (stat),
        .result (result)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import olte_pkg::*;

    localparam int          DEPTH       = DEPTH_DEF;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          DRAIN_WAIT  = 16;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    done;
    result_t result;

    logic signed [31:0] list_mem [DEPTH];
    int unsigned        list_len = 0;
    result_t            pending_results [$];
    result_t            want;
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 idle_pct = 30;

    ordered_list_table_engine_top #(.DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // expected result of one list operation; updates the shadow list
    function automatic result_t apply_list_op(input item_t it);
        result_t r;
        int unsigned p;
        r = '0;
        p = it.position;
        case (it.op)
            OP_INSERT:
            begin
                if (p >= 1 && p <= list_len + 1 && list_len < DEPTH)
                begin
                    for (int unsigned j = list_len; j >= p; j--)
                        list_mem[j] = list_mem[j - 1];
                    list_mem[p - 1] = it.item_value;
                    list_len++;
                    r.success = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (p >= 1 && p <= list_len)
                begin
                    r.removed_value = list_mem[p - 1];
                    for (int unsigned j = p; j < list_len; j++)
                        list_mem[j - 1] = list_mem[j];
                    list_len--;
                    r.success = 1'b1;
                end
            end
            OP_LOCATE:
            begin
                for (int unsigned j = 0; j < list_len; j++)
                begin
                    if (r.found_position == 0 && list_mem[j] == it.item_value)
                        r.found_position = 7'(j + 1);
                end
                r.success = (r.found_position != 0);
            end
            default: ;
        endcase
        r.list_count = 7'(list_len);
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3, 4: return 32'($signed($urandom_range(8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [6:0] pos,
                             input logic signed [31:0] val);
        item_t it;
        it.op = op;
        it.position = pos;
        it.item_value = val;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        pending_results.push_back(apply_list_op(it));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.success !== want.success
                    || result.removed_value !== want.removed_value
                    || result.found_position !== want.found_position
                    || result.list_count !== want.list_count)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected ok=%0b rm=%0d pos=%0d cnt=%0d,",
                                 want.success, want.removed_value,
                                 want.found_position, want.list_count,
                                 " got ok=%0b rm=%0d pos=%0d cnt=%0d",
                                 result.success, result.removed_value,
                                 result.found_position, result.list_count);
                end
            end
        end
    end

    task automatic test_edge_cases();
        send_item(OP_DELETE, 7'd1, 32'sd0);
        send_item(OP_LOCATE, 7'd0, 32'sd0);
        send_item(OP_INSERT, 7'd0, 32'sd9);
        send_item(OP_INSERT, 7'd2, 32'sd9);
        send_item(OP_INSERT, 7'd1, 32'sh8000_0000);
        send_item(OP_INSERT, 7'd2, 32'sh7fff_ffff);
        send_item(OP_INSERT, 7'd1, 32'sd5);
        send_item(OP_INSERT, 7'd2, -32'sd1);
        send_item(OP_INSERT, 7'd5, 32'sd5);
        send_item(OP_INSERT, 7'd127, 32'sd7);
        send_item(OP_LOCATE, 7'd0, 32'sd5);
        send_item(OP_LOCATE, 7'd127, 32'sh7fff_ffff);
        send_item(OP_LOCATE, 7'd3, 32'sd12345);
        send_item(OP_DELETE, 7'd0, 32'sd0);
        send_item(OP_DELETE, 7'd6, 32'sd0);
        send_item(OP_DELETE, 7'd127, -32'sd1);
        send_item(OP_UNUSED, 7'd127, -32'sd1);
        send_item(OP_DELETE, 7'd2, 32'sd0);
        send_item(OP_DELETE, 7'd4, 32'sd0);
        send_item(OP_DELETE, 7'd1, 32'sd0);
        send_item(OP_LOCATE, 7'd1, 32'sh8000_0000);
    endtask

    // fill to capacity from front, back and middle, overflow, then empty it
    task automatic test_fill_and_drain();
        int unsigned p;
        while (list_len < DEPTH)
        begin
            case ($urandom_range(2))
                0: p = 1;
                1: p = list_len + 1;
                default: p = $urandom_range(list_len + 1, 1);
            endcase
            send_item(OP_INSERT, 7'(p), $urandom);
        end
        send_item(OP_INSERT, 7'd1, 32'sd1);
        send_item(OP_INSERT, 7'd65, 32'sd1);
        send_item(OP_LOCATE, 7'd0, list_mem[DEPTH - 1]);
        send_item(OP_DELETE, 7'd64, 32'sd0);
        send_item(OP_INSERT, 7'd64, 32'sh7fff_ffff);
        send_item(OP_LOCATE, 7'd64, 32'sh7fff_ffff);
        while (list_len > 0)
        begin
            p = ($urandom_range(1) == 0) ? 1 : list_len;
            send_item(OP_DELETE, 7'(p), 32'sd0);
        end
        send_item(OP_DELETE, 7'd1, 32'sd0);
    endtask

    // random walk between empty and full, mostly legal positions
    task automatic test_random(input int n_items, input int pct);
        int unsigned sel;
        int unsigned ins_pct;
        int unsigned del_pct;
        bit          growing;
        growing = 1'b1;
        idle_pct = pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (list_len == DEPTH)
                growing = 1'b0;
            else if (list_len == 0)
                growing = 1'b1;
            ins_pct = growing ? 55 : 20;
            del_pct = growing ? 20 : 55;
            sel = $urandom_range(99);
            if (sel < 8)
                send_item(2'($urandom_range(3)), 7'($urandom_range(127)), $urandom);
            else if (sel < 8 + ins_pct)
                send_item(OP_INSERT, 7'($urandom_range(list_len + 1, 1)), pick_value());
            else if (sel < 8 + ins_pct + del_pct)
                send_item(OP_DELETE,
                          7'(list_len == 0 ? $urandom_range(3, 1)
                                           : $urandom_range(list_len, 1)),
                          pick_value());
            else if (list_len > 0 && $urandom_range(3) != 0)
                send_item(OP_LOCATE, 7'($urandom_range(127)),
                          list_mem[$urandom_range(list_len - 1)]);
            else
                send_item(OP_LOCATE, 7'($urandom_range(127)), pick_value());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_fill_and_drain();
        test_random(480, 30);
        test_random(480, 85);
        test_random(480, 0);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        error_count += pending_results.size();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
